FILE: rtl/core/led_pulse_width_bit_decoder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the LED pulse width bit decoder
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef LED_PULSE_WIDTH_BIT_DECODER_MACROS_SVH
`define LED_PULSE_WIDTH_BIT_DECODER_MACROS_SVH

// same-cycle implication
`define LPWD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpwd same-cycle check failed");

// next-cycle implication
`define LPWD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpwd next-cycle check failed");

`endif

FILE: rtl/core/lpwd_pkg.sv
// ---------------------------------------------------------------------------
// lpwd_pkg
// Types and constants of the LED pulse width bit decoder.
// ---------------------------------------------------------------------------
package lpwd_pkg;

  localparam int STAMP_W      = 32;
  localparam int LEN_W        = 16;
  localparam int BUFFER_BYTES = 2048;
  localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
  localparam int INDEX_W      = 11;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;

  typedef enum logic [2:0] {
    REG_ZERO_L0  = 3'd0,
    REG_ZERO_L1  = 3'd1,
    REG_ONE_L0   = 3'd2,
    REG_ONE_L1   = 3'd3,
    REG_FRAME_GAP = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]      zero_l0_win;
    logic [31:0]      zero_l1_win;
    logic [31:0]      one_l0_win;
    logic [31:0]      one_l1_win;
    logic [LEN_W-1:0] frame_gap_min;
  } cfg_t;

  typedef struct packed {
    logic [STAMP_W-1:0] l0_start;
    logic [STAMP_W-1:0] l1_start;
    logic [LEN_W-1:0]   l0_len;
    logic [LEN_W-1:0]   l1_len;
    logic [7:0]         shifter;
    logic [2:0]         bit_pos;
    logic [POS_W-1:0]   byte_pos;
  } state_t;

  // packed lowest field last, so it maps straight onto out_tdata
  typedef struct packed {
    logic               buffer_full;
    logic               frame_restart;
    logic [INDEX_W-1:0] byte_index;
    logic [7:0]         byte_value;
    logic               byte_done;
    logic               bit_value;
    logic               bit_added;
  } result_t;

endpackage

FILE: rtl/core/lpwd_step.sv
// ---------------------------------------------------------------------------
// lpwd_step
// Decode logic for one line transition: phase length, window match, shifter.
// ---------------------------------------------------------------------------
module lpwd_step
  import lpwd_pkg::*;
(
  input  state_t             st,
  input  cfg_t               cfg,
  input  logic               new_level,
  input  logic [STAMP_W-1:0] stamp,
  output state_t             st_nxt,
  output result_t            res
);

  logic [STAMP_W-1:0] diff;
  logic [LEN_W-1:0]   sat_len;
  logic [LEN_W-1:0]   len0;
  logic [LEN_W-1:0]   len1;
  logic               is_zero;
  logic               is_one;
  logic [2:0]         bit_pos_inc;

  function automatic logic in_win(input logic [LEN_W-1:0] len, input logic [31:0] win);
    in_win = (len >= win[15:0]) && (len <= win[31:16]);
  endfunction

  // measure the phase that just ended, modulo the stamp width
  assign diff    = stamp - (new_level ? st.l0_start : st.l1_start);
  assign sat_len = (|diff[STAMP_W-1:LEN_W]) ? {LEN_W{1'b1}} : diff[LEN_W-1:0];
  assign len0    = new_level ? sat_len : st.l0_len;
  assign len1    = new_level ? st.l1_len : sat_len;

  assign is_zero = in_win(len0, cfg.zero_l0_win) && in_win(len1, cfg.zero_l1_win);
  assign is_one  = !is_zero && in_win(len0, cfg.one_l0_win) && in_win(len1, cfg.one_l1_win);
  assign bit_pos_inc = st.bit_pos + 3'd1;

  always_comb begin
    st_nxt = st;
    res    = '0;
    st_nxt.l0_len = len0;
    st_nxt.l1_len = len1;
    if (new_level) begin
      st_nxt.l1_start = stamp;
    end else begin
      st_nxt.l0_start = stamp;
    end
    if (new_level) begin
      if (is_zero || is_one) begin
        if (st.byte_pos >= POS_W'(BUFFER_BYTES)) begin
          res.buffer_full = 1'b1;
        end else begin
          res.bit_added  = 1'b1;
          res.bit_value  = is_one;
          st_nxt.shifter = {st.shifter[6:0], is_one};
          st_nxt.bit_pos = bit_pos_inc;
          if (bit_pos_inc == 3'd0) begin
            res.byte_done   = 1'b1;
            res.byte_value  = {st.shifter[6:0], is_one};
            res.byte_index  = st.byte_pos[INDEX_W-1:0];
            st_nxt.byte_pos = st.byte_pos + POS_W'(1);
          end
        end
      end else if (len0 >= cfg.frame_gap_min) begin
        res.frame_restart = 1'b1;
        st_nxt.bit_pos    = '0;
        st_nxt.byte_pos   = '0;
      end
    end
  end

endmodule

FILE: rtl/core/led_pulse_width_bit_decoder.sv
// ---------------------------------------------------------------------------
// led_pulse_width_bit_decoder
// Single-wire LED data line decoder: transitions in, decoded bits and bytes out.
// ---------------------------------------------------------------------------
// Registers: input reg, then result reg; a transition is decoded between them
//   and its result is held in the result register that drives out_tvalid.
// Throughput: 1 transition per cycle unless the result stream stalls; the decode
//   stage updates the line state in the same cycle it loads the result register.
// Reset (rst_n low, synchronous): windows return to defaults, line state,
//   shifter and positions clear, both pipeline registers empty.
module led_pulse_width_bit_decoder
  import lpwd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,   // [0] new_level, [32:1] stamp, [39:33] zero
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [0] bit_added, [1] bit_value, [2] byte_done,
                                            // [10:3] byte_value, [21:11] byte_index,
                                            // [22] frame_restart, [23] buffer_full
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  `include "led_pulse_width_bit_decoder_macros.svh"

  cfg_t               cfg_r;
  state_t             st_r;
  state_t             st_nxt;
  result_t            res_nxt;
  result_t            out_r;
  logic               in_v_r;
  logic               in_lvl_r;
  logic [STAMP_W-1:0] in_stamp_r;
  logic               out_v_r;
  logic               advance;
  logic               step_fire;
  logic               in_fire;
  logic               cfg_wr;
  cfg_reg_t           cfg_sel;

  // -------------------------------------------------------------------------
  // Configuration registers: APB write on the access phase, zero-wait reads
  // -------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_l0_win   <= 32'd1048588;
      cfg_r.zero_l1_win   <= 32'd589829;
      cfg_r.one_l0_win    <= 32'd524293;
      cfg_r.one_l1_win    <= 32'd983051;
      cfg_r.frame_gap_min <= LEN_W'(807);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_ZERO_L0:   cfg_r.zero_l0_win   <= cfg_pwdata;
        REG_ZERO_L1:   cfg_r.zero_l1_win   <= cfg_pwdata;
        REG_ONE_L0:    cfg_r.one_l0_win    <= cfg_pwdata;
        REG_ONE_L1:    cfg_r.one_l1_win    <= cfg_pwdata;
        REG_FRAME_GAP: cfg_r.frame_gap_min <= cfg_pwdata[LEN_W-1:0];
        default: ;  // unmapped addresses drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ZERO_L0:   cfg_prdata = cfg_r.zero_l0_win;
      REG_ZERO_L1:   cfg_prdata = cfg_r.zero_l1_win;
      REG_ONE_L0:    cfg_prdata = cfg_r.one_l0_win;
      REG_ONE_L1:    cfg_prdata = cfg_r.one_l1_win;
      REG_FRAME_GAP: cfg_prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, cfg_r.frame_gap_min};
      default:       cfg_prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Pipeline control: the decode stage advances whenever the result register
  // is empty or being drained; the input register refills in the same cycle.
  // -------------------------------------------------------------------------
  assign advance   = !out_v_r || out_tready;
  assign step_fire = in_v_r && advance;
  assign in_tready = !in_v_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  // input payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_lvl_r   <= in_tdata[0];
      in_stamp_r <= in_tdata[STAMP_W:1];
    end
  end

  // -------------------------------------------------------------------------
  // Decode stage: one transition against the current line state
  // -------------------------------------------------------------------------
  lpwd_step u_step (
    .st        (st_r),
    .cfg       (cfg_r),
    .new_level (in_lvl_r),
    .stamp     (in_stamp_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  // advance line state only when the transition leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_fire) begin
      st_r <= st_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `LPWD_ASSERT_NOW(a_pos_bound, 1'b1, st_r.byte_pos <= POS_W'(BUFFER_BYTES))
  `LPWD_ASSERT_NEXT(a_byte_wraps, step_fire && res_nxt.byte_done, st_r.bit_pos == 3'd0)
  `LPWD_ASSERT_NEXT(a_restart_clears, step_fire && res_nxt.frame_restart,
                    st_r.byte_pos == '0 && st_r.bit_pos == 3'd0)
  `LPWD_ASSERT_NOW(a_full_only_at_end, step_fire && res_nxt.buffer_full,
                   st_r.byte_pos == POS_W'(BUFFER_BYTES) && !res_nxt.bit_added)

endmodule

FILE: dv/led_pulse_width_bit_decoder_tb.sv
// ----------------------------------------------------------------------------
// LED pulse width bit decoder testbench
// Feeds line transitions built from pulse pairs (zero bits, one bits, frame
// gaps, near misses and raw noise) under several window settings, predicts
// every result in a scoreboard and checks the result stream field by field,
// with random idling on both streams.
// ----------------------------------------------------------------------------
module led_pulse_width_bit_decoder_tb
  import lpwd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;

  // Default window settings, loaded by reset and restored for the last burst.
  localparam logic [31:0] DEF_ZERO_L0 = 32'h0010_000C;
  localparam logic [31:0] DEF_ZERO_L1 = 32'h0009_0005;
  localparam logic [31:0] DEF_ONE_L0  = 32'h0008_0005;
  localparam logic [31:0] DEF_ONE_L1  = 32'h000F_000B;
  localparam logic [31:0] DEF_GAP     = 32'd807;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the line state and the frame, holds due results.
  // --------------------------------------------------------------------------
  class line_decode_tracker;
    logic [31:0] zero_l0_win, zero_l1_win, one_l0_win, one_l1_win;
    logic [15:0] gap_min;
    logic [31:0] l0_start, l1_start;
    logic [15:0] l0_len, l1_len;
    logic [7:0]  shifter;
    logic [2:0]  bit_pos;
    logic [11:0] byte_pos;
    result_t     due_results[$];
    int          errors;

    function new();
      zero_l0_win = DEF_ZERO_L0;
      zero_l1_win = DEF_ZERO_L1;
      one_l0_win  = DEF_ONE_L0;
      one_l1_win  = DEF_ONE_L1;
      gap_min     = DEF_GAP[15:0];
      l0_start = '0;
      l1_start = '0;
      l0_len   = '0;
      l1_len   = '0;
      shifter  = '0;
      bit_pos  = '0;
      byte_pos = '0;
      errors   = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] value);
      case (idx)
        REG_ZERO_L0:   zero_l0_win = value;
        REG_ZERO_L1:   zero_l1_win = value;
        REG_ONE_L0:    one_l0_win  = value;
        REG_ONE_L1:    one_l1_win  = value;
        REG_FRAME_GAP: gap_min     = value[15:0];
        default: ;
      endcase
    endfunction

    static function logic in_window(logic [15:0] len, logic [31:0] win);
      return len >= win[15:0] && len <= win[31:16];
    endfunction

    // saturate a phase length to 16 bits
    static function logic [15:0] clip(logic [31:0] span);
      return (span > 32'h0000_FFFF) ? 16'hFFFF : span[15:0];
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void take_edge(logic lvl, logic [31:0] stamp);
      result_t r;
      logic    zero_hit, one_hit;
      r = '0;
      if (lvl) begin
        l0_len   = clip(stamp - l0_start);
        l1_start = stamp;
      end else begin
        l1_len   = clip(stamp - l1_start);
        l0_start = stamp;
      end
      if (lvl) begin
        zero_hit = in_window(l0_len, zero_l0_win) && in_window(l1_len, zero_l1_win);
        one_hit  = !zero_hit && in_window(l0_len, one_l0_win) &&
                   in_window(l1_len, one_l1_win);
        if (zero_hit || one_hit) begin
          if (byte_pos >= BUFFER_BYTES) begin
            r.buffer_full = 1'b1;
          end else begin
            r.bit_added = 1'b1;
            r.bit_value = one_hit;
            shifter = {shifter[6:0], one_hit};
            bit_pos = bit_pos + 3'd1;
            if (bit_pos == 3'd0) begin
              r.byte_done  = 1'b1;
              r.byte_value = shifter;
              r.byte_index = byte_pos[INDEX_W-1:0];
              byte_pos = byte_pos + 12'd1;
            end
          end
        end else if (l0_len >= gap_min) begin
          r.frame_restart = 1'b1;
          bit_pos  = '0;
          byte_pos = '0;
        end
      end
      due_results.push_back(r);
    endfunction

    task flag_mismatch(string msg);
      $display("decoder mismatch: %s", msg);
      errors++;
    endtask

    task cmp(string field, int unsigned got, int unsigned want);
      if (got != want)
        flag_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task match_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        flag_mismatch("result with no request outstanding");
        return;
      end
      want = due_results.pop_front();
      cmp("bit_added", got.bit_added, want.bit_added);
      cmp("bit_value", got.bit_value, want.bit_value);
      cmp("byte_done", got.byte_done, want.byte_done);
      cmp("byte_value", got.byte_value, want.byte_value);
      cmp("byte_index", got.byte_index, want.byte_index);
      cmp("frame_restart", got.frame_restart, want.frame_restart);
      cmp("buffer_full", got.buffer_full, want.buffer_full);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [39:0]           in_tdata;   // [0] new_level, [32:1] stamp, [39:33] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;  // [0] bit_added, [1] bit_value, [2] byte_done,
                                     // [10:3] byte_value, [21:11] byte_index,
                                     // [22] frame_restart, [23] buffer_full
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  led_pulse_width_bit_decoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_decode_tracker tracker = new();

  // Line time in cycles; pulses advance it, noise may jump it anywhere.
  logic [31:0] line_clock = '0;
  int          edges_sent = 0;
  // While set, neither stream idles.
  logic        calm = 1'b0;
  int          stall_left = 0;

  // Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
  function automatic int pick_gap();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(99, 0);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Random length inside a window; an empty window yields its minimum.
  function automatic int pick_in(logic [31:0] win);
    if (win[31:16] < win[15:0])
      return int'(win[15:0]);
    return $urandom_range(int'(win[31:16]), int'(win[15:0]));
  endfunction

  function automatic logic [31:0] make_win(int lo_max, int span_max);
    int lo, hi;
    lo = $urandom_range(lo_max, 0);
    hi = lo + $urandom_range(span_max, 0);
    return {hi[15:0], lo[15:0]};
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check each accepted result, then stall at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (out_tvalid && out_tready)
      tracker.match_result(result_t'(out_tdata));
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_tready <= (stall_left == 0);
    end
  end

  // Watchdog: end the run once nothing moves on either stream for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Present one transition and hold it until accepted.
  task automatic send_edge(logic lvl, logic [31:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, stamp, lvl};
    do @(posedge clk); while (!in_tready);
    tracker.take_edge(lvl, stamp);
    edges_sent++;
  endtask

  // One high phase, then one low phase closed by the next rising edge.
  task automatic send_phases(int high_len, int low_len);
    line_clock = line_clock + 32'(high_len);
    send_edge(1'b0, line_clock);
    line_clock = line_clock + 32'(low_len);
    send_edge(1'b1, line_clock);
  endtask

  task automatic send_data_bit(logic one);
    if (one)
      send_phases(pick_in(tracker.one_l1_win), pick_in(tracker.one_l0_win));
    else
      send_phases(pick_in(tracker.zero_l1_win), pick_in(tracker.zero_l0_win));
  endtask

  task automatic send_frame_gap();
    send_phases($urandom_range(20, 1), int'(tracker.gap_min) + $urandom_range(300, 0));
  endtask

  // Drop valid and wait until every result is back, then let the pipeline settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // edge where the access completes.
  task automatic cfg_write(cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic load_windows(logic [31:0] z0, logic [31:0] z1, logic [31:0] o0,
                              logic [31:0] o1, logic [31:0] gap);
    drain();
    cfg_write(REG_ZERO_L0, z0);
    cfg_write(REG_ZERO_L1, z1);
    cfg_write(REG_ONE_L0, o0);
    cfg_write(REG_ONE_L1, o1);
    cfg_write(REG_FRAME_GAP, gap);
  endtask

  // Mostly well-formed bits with random content and the odd frame gap;
  // the rest is near misses just outside a window and raw line noise.
  task automatic run_stream(int count);
    int    target, pick, hi_len, lo_len;
    logic  one;
    target = edges_sent + count;
    while (edges_sent < target) begin
      pick = $urandom_range(99, 0);
      one  = $urandom_range(1, 0);
      if (pick < 4) begin
        send_frame_gap();
      end else if (pick < 78) begin
        send_data_bit(one);
      end else if (pick < 88) begin
        hi_len = pick_in(one ? tracker.one_l1_win : tracker.zero_l1_win);
        lo_len = pick_in(one ? tracker.one_l0_win : tracker.zero_l0_win);
        // push one of the two lengths just past a window edge
        if ($urandom_range(1, 0))
          lo_len = $urandom_range(1, 0) ? lo_len + 9 : lo_len - 6;
        else
          hi_len = $urandom_range(1, 0) ? hi_len + 9 : hi_len - 6;
        send_phases(hi_len, lo_len);
      end else begin
        pick = $urandom_range(7, 0);
        if (pick == 0)
          line_clock = $urandom;
        else if (pick == 1)
          line_clock = line_clock + 32'd70000;
        else
          line_clock = line_clock + 32'($urandom_range(40, 0));
        send_edge($urandom_range(1, 0), line_clock);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : main
    logic [7:0] pattern;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, at reset windows. Stamp of all zeros: both lengths zero,
    // no bit, no restart.
    send_edge(1'b1, 32'h0000_0000);
    // Falling edge far away: level-1 length saturates.
    send_edge(1'b0, 32'hFFFF_FFF0);
    // Stamp wraps past zero: level-0 length 1040 restarts the frame.
    line_clock = 32'h0000_0400;
    send_edge(1'b1, line_clock);
    // A full byte, mixing zero and one bits.
    pattern = 8'hA5;
    for (int i = 7; i >= 0; i--)
      send_data_bit(pattern[i]);
    // Repeated rising level, then repeated falling level.
    line_clock = line_clock + 32'd3;
    send_edge(1'b1, line_clock);
    line_clock = line_clock + 32'd6;
    send_edge(1'b0, line_clock);
    line_clock = line_clock + 32'd6;
    send_edge(1'b0, line_clock);
    // Stamp of all ones.
    line_clock = 32'hFFFF_FFFF;
    send_edge(1'b1, line_clock);

    run_stream(220);

    // Overlapping windows: zero bit takes priority; no idling here.
    load_windows(32'h000C_0003, 32'h000C_0003, 32'h0014_0003, 32'h0014_0003, 32'd40);
    calm = 1'b1;
    run_stream(150);
    calm = 1'b0;

    // Everything matches as a zero bit; the frame never restarts.
    load_windows(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'd0);
    run_stream(60);

    // Empty windows with no gap minimum: every rising edge restarts.
    load_windows(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'd0);
    run_stream(60);

    // Only saturated lengths match; the gap minimum is at its top.
    load_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF);
    run_stream(60);

    // Random small windows.
    repeat (3) begin
      load_windows(make_win(30, 12), make_win(30, 12), make_win(30, 12),
                   make_win(30, 12), $urandom_range(200, 20));
      run_stream(80);
    end

    // Back at default windows: restart the frame, then a short burst of bits.
    load_windows(DEF_ZERO_L0, DEF_ZERO_L1, DEF_ONE_L0, DEF_ONE_L1, DEF_GAP);
    send_frame_gap();
    repeat (12)
      send_data_bit($urandom_range(1, 0));
    run_stream(100);

    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/lpwd_pkg.sv
rtl/core/lpwd_step.sv
rtl/core/led_pulse_width_bit_decoder.sv
dv/led_pulse_width_bit_decoder_tb.sv
